[rtl/padding_aware_batch_former_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the padding-aware batch former
// Shared checks written against clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PADDING_AWARE_BATCH_FORMER_TOP_MACROS_SVH
`define PADDING_AWARE_BATCH_FORMER_TOP_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define PABF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define PABF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/pabf_pkg.sv]
// ----------------------------------------------------------------------------
// pabf_pkg
// Widths, constants and shared types of the padding-aware batch former.
// ----------------------------------------------------------------------------
package pabf_pkg;

  localparam int LEN_W     = 16;
  localparam int COUNT_W   = 8;
  localparam int TOTAL_W   = 23;
  localparam int MAX_BATCH = 128;

  // Saturation value of the running token total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT     = 1'd1;
  localparam logic [COUNT_W-1:0]   BATCH_SIZE_LIMIT_RST = 8'd8;
  localparam logic [LEN_W-1:0]     LENGTH_LIMIT_RST     = 16'd2048;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Padding test widths: 5*(total+len) against 4*(count+1)*max
  localparam int SUM_W  = TOTAL_W + 1;
  localparam int INC_W  = COUNT_W + 1;
  localparam int PROD_W = INC_W + LEN_W;
  localparam int CMP_W  = ((SUM_W + 3) > (PROD_W + 2)) ? (SUM_W + 3) : (PROD_W + 2);

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_FLUSH   = 1'b1
  } op_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic             flush;
    logic             len_over;
    logic [LEN_W-1:0] seq_len;
  } item_t;

  // One result as held for the receiver
  typedef struct packed {
    logic               accepted;
    logic               batch_closed;
    logic [COUNT_W-1:0] closed_count;
    logic [LEN_W-1:0]   closed_max_len;
    logic [TOTAL_W-1:0] closed_total;
  } result_t;

endpackage

[rtl/pabf_front.sv]
// ----------------------------------------------------------------------------
// pabf_front
// Input stage: captures a request, decodes the op and flags an
// over-limit length before handing it to the queue.
// ----------------------------------------------------------------------------
module pabf_front import pabf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             op,
  input  logic [LEN_W-1:0] seq_len,
  input  logic [LEN_W-1:0] length_limit,
  output logic             stage_valid,
  output item_t            stage_item,
  input  logic             q_ready
);

  logic  stage_valid_next;
  logic  take;
  item_t item_next;

  // Accept when the stage is empty or drains this cycle
  assign full = stage_valid && !q_ready;
  assign take = push && !full;
  assign stage_valid_next = take || (stage_valid && !q_ready);

  // Classify the incoming request
  always_comb begin
    item_next.flush    = (op_t'(op) == OP_FLUSH);
    item_next.len_over = (seq_len > length_limit);
    item_next.seq_len  = seq_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // Hold the payload unless a new request is taken
  always_ff @(posedge clk) begin
    if (take) begin
      stage_item <= item_next;
    end
  end

endmodule

[rtl/pabf_queue.sv]
// ----------------------------------------------------------------------------
// pabf_queue
// Short FIFO of classified requests between the front and back stages.
// ----------------------------------------------------------------------------
module pabf_queue import pabf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_take
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              wr_en;
  logic              rd_en;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_take && out_valid;

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + QCNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_next = count - QCNT_W'(1);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

[rtl/pabf_back.sv]
// ----------------------------------------------------------------------------
// pabf_back
// Admission unit: keeps the open batch, runs the size, length and padding
// tests on each request and registers one result per request.
// ----------------------------------------------------------------------------
module pabf_back import pabf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               in_take,
  input  logic [COUNT_W-1:0] size_limit,
  input  logic [LEN_W-1:0]   length_limit,
  input  logic               pop,
  output logic               res_valid,
  output result_t            res
);

  logic [COUNT_W-1:0] open_count;
  logic [LEN_W-1:0]   open_max_len;
  logic [TOTAL_W-1:0] open_total;
  logic [COUNT_W-1:0] open_count_next;
  logic [LEN_W-1:0]   open_max_len_next;
  logic [TOTAL_W-1:0] open_total_next;
  logic               res_valid_next;
  result_t            res_next;

  logic [LEN_W-1:0]   new_max;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;
  logic [INC_W-1:0]   count_inc;
  logic [COUNT_W-1:0] add_count;
  logic [PROD_W-1:0]  prod;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;
  logic               fits;
  logic               batch_open;

  // Take a request when the result register is free or drains this cycle
  assign in_take = in_valid && (!res_valid || pop);

  // Candidate batch after adding the request
  assign batch_open = (open_count != '0);
  assign new_max    = (in_item.seq_len > open_max_len) ? in_item.seq_len : open_max_len;
  assign sum        = SUM_W'(open_total) + SUM_W'(in_item.seq_len);
  assign sum_sat    = sum[SUM_W-1] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign count_inc  = INC_W'(open_count) + INC_W'(1);
  assign add_count  = count_inc[COUNT_W-1:0];
  assign prod       = PROD_W'(count_inc) * PROD_W'(new_max);
  assign lhs        = (CMP_W'(sum) << 2) + CMP_W'(sum);
  assign rhs        = CMP_W'(prod) << 2;

  // Admission tests on a non-empty batch
  assign fits = (open_count < size_limit) && !in_item.len_over &&
                (open_max_len <= length_limit) && (new_max != '0) && (lhs >= rhs);

  always_comb begin
    open_count_next   = open_count;
    open_max_len_next = open_max_len;
    open_total_next   = open_total;
    res_valid_next    = res_valid && !pop;
    res_next          = res;
    if (in_take) begin
      res_valid_next = 1'b1;
      res_next       = '0;
      if (in_item.flush || (batch_open && !fits)) begin
        // Close the open batch; a refused request is dropped for requeue
        if (batch_open) begin
          res_next.batch_closed   = 1'b1;
          res_next.closed_count   = open_count;
          res_next.closed_max_len = open_max_len;
          res_next.closed_total   = open_total;
        end
        open_count_next   = '0;
        open_max_len_next = '0;
        open_total_next   = '0;
      end else begin
        res_next.accepted = 1'b1;
        if (add_count >= size_limit) begin
          // Batch filled to the size limit: close it with this request
          res_next.batch_closed   = 1'b1;
          res_next.closed_count   = add_count;
          res_next.closed_max_len = new_max;
          res_next.closed_total   = sum_sat;
          open_count_next         = '0;
          open_max_len_next       = '0;
          open_total_next         = '0;
        end else begin
          open_count_next   = add_count;
          open_max_len_next = new_max;
          open_total_next   = sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count   <= '0;
      open_max_len <= '0;
      open_total   <= '0;
      res_valid    <= 1'b0;
    end else begin
      open_count   <= open_count_next;
      open_max_len <= open_max_len_next;
      open_total   <= open_total_next;
      res_valid    <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

[rtl/padding_aware_batch_former_top.sv]
// ----------------------------------------------------------------------------
// padding_aware_batch_former_top
// Forms batches of requests under size, length and 20 percent padding limits.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each request carries op (request or flush) and
// seq_len. Result channel: empty/pop; exactly one result per request, in
// order, with accepted, batch_closed and the closed batch's count, longest
// length and token total (all zero when nothing closes).
// Config channel: cfg_valid/cfg_ready with cfg_index 0 = batch_size_limit,
// 1 = length_limit; cfg_ready is always high. Write only while idle.
// A request passes the input stage, the queue and the result register, in
// that order, before it is visible on the result ports.
// Throughput: one request per cycle while the receiver keeps up; the
// open-batch update and the 9x16-bit padding multiply with its compare are combinational.
// Reset empties the input stage, the 4-entry queue and the result register,
// clears the open batch and restores the limits to 8 and 2048.
// When the receiver stalls, the result register holds, the queue fills
// behind it and full rises once the queue and input stage are occupied.
// ----------------------------------------------------------------------------
`include "padding_aware_batch_former_top_macros.svh"

module padding_aware_batch_former_top import pabf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  op,
  input  logic [LEN_W-1:0]      seq_len,
  output logic                  empty,
  input  logic                  pop,
  output logic                  accepted,
  output logic                  batch_closed,
  output logic [COUNT_W-1:0]    closed_count,
  output logic [LEN_W-1:0]      closed_max_len,
  output logic [TOTAL_W-1:0]    closed_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] batch_size_limit;
  logic [LEN_W-1:0]   length_limit;
  logic [COUNT_W-1:0] size_limit;
  logic               stage_valid;
  item_t              stage_item;
  logic               q_ready;
  logic               q_valid;
  item_t              q_item;
  logic               q_take;
  logic               res_valid;
  result_t            res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size_limit <= BATCH_SIZE_LIMIT_RST;
      length_limit     <= LENGTH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BATCH_SIZE_LIMIT: batch_size_limit <= cfg_data[COUNT_W-1:0];
        CFG_LENGTH_LIMIT:     length_limit     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the size limit into 1..MAX_BATCH
  always_comb begin
    if (batch_size_limit == '0) begin
      size_limit = COUNT_W'(1);
    end else if (batch_size_limit > COUNT_W'(MAX_BATCH)) begin
      size_limit = COUNT_W'(MAX_BATCH);
    end else begin
      size_limit = batch_size_limit;
    end
  end

  pabf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .seq_len      (seq_len),
    .length_limit (length_limit),
    .stage_valid  (stage_valid),
    .stage_item   (stage_item),
    .q_ready      (q_ready)
  );

  pabf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid),
    .in_item   (stage_item),
    .in_ready  (q_ready),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_take  (q_take)
  );

  pabf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_item      (q_item),
    .in_take      (q_take),
    .size_limit   (size_limit),
    .length_limit (length_limit),
    .pop          (pop),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign empty          = !res_valid;
  assign accepted       = res.accepted;
  assign batch_closed   = res.batch_closed;
  assign closed_count   = res.closed_count;
  assign closed_max_len = res.closed_max_len;
  assign closed_total   = res.closed_total;

  // A closed batch always holds at least one request and never more than the cap
  `PABF_ASSERT(a_closed_nonempty,
    (!empty && batch_closed) |-> (closed_count != '0 && closed_count <= COUNT_W'(MAX_BATCH)),
    "closed batch count out of range")
  // Without a close the batch fields read zero
  `PABF_ASSERT(a_open_fields_zero,
    (!empty && !batch_closed) |->
      (closed_count == '0 && closed_max_len == '0 && closed_total == '0),
    "batch fields set without a close")
  // The back stage never takes a request while a stalled result is held
  `PABF_ASSERT_NEVER(a_no_overwrite, q_take && res_valid && !pop, "result overwritten while stalled")

endmodule
